// File: rtl/core/dbn_pkg.sv
// Shared types, constants and state encodings of the detection box decode and NMS block.
`timescale 1ns / 1ps
package dbn_pkg;

   localparam int MaxCand    = 1024;
   localparam int NumClasses = 80;
   localparam int MaxKept    = 64;

   localparam int CandAw   = $clog2(MaxCand);
   localparam int CandCntW = $clog2(MaxCand + 1);
   localparam int KeptAw   = (MaxKept > 1) ? $clog2(MaxKept) : 1;
   localparam int KeptCntW = $clog2(MaxKept + 1);
   localparam int ClsW     = 7;
   localparam int ClsCntW  = $clog2(NumClasses + 1);
   localparam int CsrIdxW  = 3;

   // Register indexes of the configuration port
   localparam logic [CsrIdxW-1:0] CSR_SCORE_THR   = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_OVERLAP_THR = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_PAD_LEFT    = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_PAD_TOP     = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_INV_SCALE   = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_FRAME_W     = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_FRAME_H     = 3'd6;

   typedef struct packed {
      logic [15:0] center_x;
      logic [15:0] center_y;
      logic [15:0] box_width;
      logic [15:0] box_height;
      logic [15:0] class_score;
      logic        last_of_anchor;
      logic        last_of_frame;
   } req_type;

   typedef struct packed {
      logic            valid_res;
      logic [15:0]     left;
      logic [15:0]     top;
      logic [15:0]     out_width;
      logic [15:0]     out_height;
      logic [ClsW-1:0] class_id;
      logic [15:0]     score_out;
      logic            overflow;
      logic            last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] score_threshold;
      logic [15:0] overlap_threshold;
      logic [9:0]  pad_left;
      logic [9:0]  pad_top;
      logic [23:0] inverse_scale;
      logic [11:0] frame_width;
      logic [11:0] frame_height;
   } cfg_type;

   typedef struct packed {
      logic [15:0] l;
      logic [15:0] t;
      logic [15:0] w;
      logic [15:0] h;
   } box_type;

   typedef struct packed {
      box_type         box;
      logic [15:0]     score;
      logic [ClsW-1:0] cls;
   } cand_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECODE, ST_INS_CMP, ST_INS_WR, ST_NMS_GO, ST_NMS
   } top_state_type;

   typedef enum logic [1:0] {
      DS_IDLE, DS_MUL, DS_RND, DS_CLIP
   } dec_state_type;

   typedef enum logic [3:0] {
      NS_IDLE, NS_CRD, NS_CLAT, NS_KLAT, NS_M0, NS_M1, NS_M2, NS_M3, NS_M4,
      NS_DECIDE, NS_NEXT, NS_ELAT, NS_EMIT
   } nms_state_type;

endpackage

// File: rtl/core/detection_box_decode_nms_core.sv
// Top level: class scoring, candidate store with sorted insertion, decoder and NMS.
`timescale 1ns / 1ps
// One score item is taken per cycle while req_ready is high. An anchor-ending
// item that passes the score threshold, with room left in the store, holds
// req_ready low through box decode on the shared multiplier, the store write
// and the sorted insertion, which shifts each stored candidate with a lower
// score down the candidate memory. At frame end the NMS walk reads each
// candidate, tests it only against same-class kept boxes, skipping the IoU
// test for other-class ones, and then presents each result in turn.
// req_ready returns once the frame's last result transaction is taken. The
// candidate store needs no clearing after reset.
module detection_box_decode_nms_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  dbn_pkg::req_type               req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output dbn_pkg::rsp_type               rsp_payload,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [dbn_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [23:0]                    csr_data
);
   import dbn_pkg::*;

   top_state_type        state_ff, state_in;
   cfg_type              cfg_ff;
   logic [15:0]          best_score_ff, best_score_in;
   logic [ClsW-1:0]      best_class_ff, best_class_in;
   logic [ClsCntW-1:0]   class_cnt_ff, class_cnt_in;
   logic [CandCntW-1:0]  cand_cnt_ff, cand_cnt_in;
   logic                 ovf_ff, ovf_in;
   logic                 frame_end_ff, frame_end_in;
   req_type              hold_ff, hold_in;
   cand_type             new_ff, new_in;
   logic [CandAw-1:0]    pos_ff, pos_in;
   logic                 dec_start;

   // candidate store
   cand_type             cand_mem [MaxCand];
   cand_type             cand_rd_ff;
   logic [CandAw-1:0]    cand_rd_addr, ins_rd_addr, nms_rd_addr, cand_wr_addr;
   cand_type             cand_wr_data;
   logic                 cand_we;

   logic                 dec_done, nms_start, nms_done, req_fire;
   box_type              dec_box;
   logic [15:0]          score_upd;
   logic [ClsW-1:0]      class_upd;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.score_threshold   <= 16'd26214;
         cfg_ff.overlap_threshold <= 16'd29491;
         cfg_ff.pad_left          <= 10'd0;
         cfg_ff.pad_top           <= 10'd0;
         cfg_ff.inverse_scale     <= 24'd65536;
         cfg_ff.frame_width       <= 12'd1920;
         cfg_ff.frame_height      <= 12'd1080;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_SCORE_THR:   cfg_ff.score_threshold   <= csr_data[15:0];
            CSR_OVERLAP_THR: cfg_ff.overlap_threshold <= csr_data[15:0];
            CSR_PAD_LEFT:    cfg_ff.pad_left          <= csr_data[9:0];
            CSR_PAD_TOP:     cfg_ff.pad_top           <= csr_data[9:0];
            CSR_INV_SCALE:   cfg_ff.inverse_scale     <= csr_data;
            CSR_FRAME_W:     cfg_ff.frame_width       <= csr_data[11:0];
            CSR_FRAME_H:     cfg_ff.frame_height      <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   // running best class of the anchor, including this item
   always_comb begin
      score_upd = best_score_ff;
      class_upd = best_class_ff;
      if (class_cnt_ff < ClsCntW'(NumClasses) && req_payload.class_score > best_score_ff) begin
         score_upd = req_payload.class_score;
         class_upd = ClsW'(class_cnt_ff);
      end
   end

   // control sequencer
   always_comb begin
      state_in      = state_ff;
      best_score_in = best_score_ff;
      best_class_in = best_class_ff;
      class_cnt_in  = class_cnt_ff;
      cand_cnt_in   = cand_cnt_ff;
      ovf_in        = ovf_ff;
      frame_end_in  = frame_end_ff;
      hold_in       = hold_ff;
      new_in        = new_ff;
      pos_in        = pos_ff;
      dec_start     = 1'b0;
      nms_start     = 1'b0;
      ins_rd_addr   = pos_ff - 1'b1;
      cand_we       = 1'b0;
      cand_wr_addr  = pos_ff;
      cand_wr_data  = new_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               best_score_in = score_upd;
               best_class_in = class_upd;
               if (class_cnt_ff < ClsCntW'(NumClasses)) begin
                  class_cnt_in = class_cnt_ff + 1'b1;
               end
               if (req_payload.last_of_anchor || req_payload.last_of_frame) begin
                  best_score_in = '0;
                  best_class_in = '0;
                  class_cnt_in  = '0;
                  frame_end_in  = req_payload.last_of_frame;
                  hold_in       = req_payload;
                  new_in.score  = score_upd;
                  new_in.cls    = class_upd;
                  if (score_upd >= cfg_ff.score_threshold &&
                      cand_cnt_ff != CandCntW'(MaxCand)) begin
                     dec_start = 1'b1;
                     state_in  = ST_DECODE;
                  end else begin
                     if (score_upd >= cfg_ff.score_threshold) begin
                        ovf_in = 1'b1;
                     end
                     if (req_payload.last_of_frame) begin
                        state_in = ST_NMS_GO;
                     end
                  end
               end
            end
         end
         ST_DECODE: begin
            if (dec_done) begin
               new_in.box  = dec_box;
               pos_in      = cand_cnt_ff[CandAw-1:0];
               ins_rd_addr = cand_cnt_ff[CandAw-1:0] - 1'b1;
               state_in    = (cand_cnt_ff == '0) ? ST_INS_WR : ST_INS_CMP;
            end
         end
         // entry pos-1 on the read port: shift it down if its score is lower
         ST_INS_CMP: begin
            if (cand_rd_ff.score < new_ff.score) begin
               cand_we      = 1'b1;
               cand_wr_data = cand_rd_ff;
               pos_in       = pos_ff - 1'b1;
               ins_rd_addr  = pos_ff - 2'd2;
               if (pos_ff == CandAw'(1)) begin
                  state_in = ST_INS_WR;
               end
            end else begin
               state_in = ST_INS_WR;
            end
         end
         ST_INS_WR: begin
            cand_we     = 1'b1;
            cand_cnt_in = cand_cnt_ff + 1'b1;
            state_in    = frame_end_ff ? ST_NMS_GO : ST_IDLE;
         end
         ST_NMS_GO: begin
            nms_start = 1'b1;
            state_in  = ST_NMS;
         end
         ST_NMS: begin
            if (nms_done) begin
               cand_cnt_in = '0;
               ovf_in      = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         best_score_ff <= '0;
         best_class_ff <= '0;
         class_cnt_ff  <= '0;
         cand_cnt_ff   <= '0;
         ovf_ff        <= 1'b0;
      end else begin
         state_ff      <= state_in;
         best_score_ff <= best_score_in;
         best_class_ff <= best_class_in;
         class_cnt_ff  <= class_cnt_in;
         cand_cnt_ff   <= cand_cnt_in;
         ovf_ff        <= ovf_in;
      end
      frame_end_ff <= frame_end_in;
      hold_ff      <= hold_in;
      new_ff       <= new_in;
      pos_ff       <= pos_in;
   end

   // candidate store port, read shared with the NMS walk
   assign cand_rd_addr = (state_ff == ST_NMS) ? nms_rd_addr : ins_rd_addr;

   always_ff @(posedge clock) begin
      if (cand_we) begin
         cand_mem[cand_wr_addr] <= cand_wr_data;
      end
      cand_rd_ff <= cand_mem[cand_rd_addr];
   end

   dbn_decode u_decode (
      .clock (clock),
      .reset (reset),
      .start (dec_start),
      .item  (state_ff == ST_IDLE ? req_payload : hold_ff),
      .cfg   (cfg_ff),
      .done  (dec_done),
      .box   (dec_box)
   );

   dbn_nms u_nms (
      .clock             (clock),
      .reset             (reset),
      .start             (nms_start),
      .cand_count        (cand_cnt_ff),
      .overflow_in       (ovf_ff),
      .overlap_threshold (cfg_ff.overlap_threshold),
      .cand_rd_addr      (nms_rd_addr),
      .cand_rd_data      (cand_rd_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_payload       (rsp_payload),
      .done              (nms_done)
   );

   // results only come out during the NMS phase
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> state_ff == ST_NMS)
      else $error("result outside NMS phase");

   // store never holds more than its depth
   assert property (@(posedge clock) disable iff (reset) cand_cnt_ff <= CandCntW'(MaxCand))
      else $error("candidate count above store depth");

   // decoder finishes only while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset) dec_done |-> state_ff == ST_DECODE)
      else $error("decode done outside decode wait");

   // a write to the store always comes from insertion
   assert property (@(posedge clock) disable iff (reset)
      cand_we |-> (state_ff == ST_INS_CMP || state_ff == ST_INS_WR))
      else $error("store write outside insertion");

endmodule

// File: rtl/core/dbn_decode.sv
// Box decoder: un-letterbox and clip with one shared multiplier over four passes.
`timescale 1ns / 1ps
module dbn_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  dbn_pkg::req_type item,
   input  dbn_pkg::cfg_type cfg,
   output logic             done,
   output dbn_pkg::box_type box
);
   import dbn_pkg::*;

   dec_state_type      state_ff, state_in;
   logic [1:0]         step_ff, step_in;
   logic signed [44:0] prod_ff, prod_in;
   logic signed [27:0] val_ff [4];
   logic signed [27:0] val_in;
   logic               done_ff, done_in;
   box_type            box_ff, box_in;

   logic signed [19:0] d_x, d_y, operand;
   logic [44:0]        mag, rnd19, rnd18, rnd;
   logic signed [28:0] x_hi, y_hi, lim_x, lim_y, x0, x1, y0, y1;

   // operand of the current pass: left, top, width, height
   always_comb begin
      d_x = $signed({3'b000, item.center_x, 1'b0}) - $signed({4'b0000, item.box_width})
            - $signed({3'b000, cfg.pad_left, 7'b0000000});
      d_y = $signed({3'b000, item.center_y, 1'b0}) - $signed({4'b0000, item.box_height})
            - $signed({3'b000, cfg.pad_top, 7'b0000000});
      case (step_ff)
         2'd0:    operand = d_x;
         2'd1:    operand = d_y;
         2'd2:    operand = $signed({4'b0000, item.box_width});
         default: operand = $signed({4'b0000, item.box_height});
      endcase
   end

   // round half away from zero; edges drop 19 bits, sizes 18
   always_comb begin
      mag   = prod_ff[44] ? 45'(-prod_ff) : 45'(prod_ff);
      rnd19 = (mag + 45'd262144) >> 19;
      rnd18 = (mag + 45'd131072) >> 18;
      rnd   = step_ff[1] ? rnd18 : rnd19;
      val_in = prod_ff[44] ? -$signed({1'b0, rnd[26:0]}) : $signed({1'b0, rnd[26:0]});
   end

   // clip to the source frame
   always_comb begin
      lim_x = $signed({13'd0, cfg.frame_width, 4'b0000});
      lim_y = $signed({13'd0, cfg.frame_height, 4'b0000});
      x_hi  = 29'(val_ff[0]) + 29'(val_ff[2]);
      y_hi  = 29'(val_ff[1]) + 29'(val_ff[3]);
      x0    = val_ff[0][27] ? 29'sd0 : 29'(val_ff[0]);
      y0    = val_ff[1][27] ? 29'sd0 : 29'(val_ff[1]);
      x1    = (x_hi > lim_x) ? lim_x : x_hi;
      y1    = (y_hi > lim_y) ? lim_y : y_hi;
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      prod_in  = prod_ff;
      done_in  = 1'b0;
      box_in   = box_ff;
      unique case (state_ff)
         DS_IDLE: begin
            if (start) begin
               step_in  = 2'd0;
               state_in = DS_MUL;
            end
         end
         DS_MUL: begin
            prod_in  = operand * $signed({1'b0, cfg.inverse_scale});
            state_in = DS_RND;
         end
         DS_RND: begin
            step_in  = step_ff + 2'd1;
            state_in = (step_ff == 2'd3) ? DS_CLIP : DS_MUL;
         end
         DS_CLIP: begin
            if (x1 <= x0 || y1 <= y0) begin
               box_in = '0;
            end else begin
               box_in.l = x0[15:0];
               box_in.t = y0[15:0];
               box_in.w = 16'(x1 - x0);
               box_in.h = 16'(y1 - y0);
            end
            done_in  = 1'b1;
            state_in = DS_IDLE;
         end
         default: state_in = DS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff <= step_in;
      prod_ff <= prod_in;
      box_ff  <= box_in;
      if (state_ff == DS_RND) begin
         val_ff[step_ff] <= val_in;
      end
   end

   assign done = done_ff;
   assign box  = box_ff;

endmodule

// File: rtl/core/dbn_nms.sv
// Greedy per-class NMS walker with a shared multiplier, kept store and result stage.
`timescale 1ns / 1ps
module dbn_nms (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [dbn_pkg::CandCntW-1:0]  cand_count,
   input  logic                          overflow_in,
   input  logic [15:0]                   overlap_threshold,
   output logic [dbn_pkg::CandAw-1:0]    cand_rd_addr,
   input  dbn_pkg::cand_type             cand_rd_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dbn_pkg::rsp_type              rsp_payload,
   output logic                          done
);
   import dbn_pkg::*;

   nms_state_type         state_ff, state_in;
   logic [CandCntW-1:0]   i_ff, i_in;
   logic [KeptCntW-1:0]   k_ff, k_in, kept_ff, kept_in;
   logic                  ovf_ff, ovf_in;
   cand_type              cur_ff, cur_in;
   logic [16:0]           iw_ff, iw_in, ih_ff, ih_in;
   logic [50:0]           prod_ff, prod_in;
   logic [33:0]           inter_ff, inter_in, area_ff, area_in, uni_ff, uni_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   // kept store
   cand_type              kept_mem [MaxKept];
   cand_type              kept_rd_ff;
   logic [KeptAw-1:0]     kept_rd_addr, kept_wr_addr;
   logic                  kept_we;

   logic [33:0]           mul_a;
   logic [16:0]           mul_b;
   logic [16:0]           al, ar, at, ab, bl, br, bt, bb, il, ir, it, ib;

   // intersection extents of kept entry and current candidate
   always_comb begin
      al = {1'b0, kept_rd_ff.box.l};
      ar = {1'b0, kept_rd_ff.box.l} + {1'b0, kept_rd_ff.box.w};
      at = {1'b0, kept_rd_ff.box.t};
      ab = {1'b0, kept_rd_ff.box.t} + {1'b0, kept_rd_ff.box.h};
      bl = {1'b0, cur_ff.box.l};
      br = {1'b0, cur_ff.box.l} + {1'b0, cur_ff.box.w};
      bt = {1'b0, cur_ff.box.t};
      bb = {1'b0, cur_ff.box.t} + {1'b0, cur_ff.box.h};
      il = (al > bl) ? al : bl;
      ir = (ar < br) ? ar : br;
      it = (at > bt) ? at : bt;
      ib = (ab < bb) ? ab : bb;
   end

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         NS_M0:   begin mul_a = {17'd0, iw_ff};               mul_b = ih_ff; end
         NS_M1:   begin mul_a = {18'd0, kept_rd_ff.box.w};    mul_b = {1'b0, kept_rd_ff.box.h}; end
         NS_M2:   begin mul_a = {18'd0, cur_ff.box.w};        mul_b = {1'b0, cur_ff.box.h}; end
         default: begin mul_a = uni_ff;                       mul_b = {1'b0, overlap_threshold}; end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      kept_in      = kept_ff;
      ovf_in       = ovf_ff;
      cur_in       = cur_ff;
      iw_in        = iw_ff;
      ih_in        = ih_ff;
      prod_in      = prod_ff;
      inter_in     = inter_ff;
      area_in      = area_ff;
      uni_in       = uni_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      cand_rd_addr = i_ff[CandAw-1:0];
      kept_rd_addr = k_ff[KeptAw-1:0];
      kept_wr_addr = kept_ff[KeptAw-1:0];
      kept_we      = 1'b0;
      done         = 1'b0;
      unique case (state_ff)
         NS_IDLE: begin
            if (start) begin
               i_in    = '0;
               kept_in = '0;
               ovf_in  = overflow_in;
               if (cand_count == '0) begin
                  rsp_in          = '0;
                  rsp_in.overflow = overflow_in;
                  rsp_in.last     = 1'b1;
                  rsp_valid_in    = 1'b1;
                  state_in        = NS_EMIT;
               end else begin
                  state_in = NS_CRD;
               end
            end
         end
         // read candidate i
         NS_CRD: state_in = NS_CLAT;
         NS_CLAT: begin
            cur_in = cand_rd_data;
            k_in   = '0;
            kept_rd_addr = '0;
            state_in = (kept_ff == '0) ? NS_DECIDE : NS_KLAT;
         end
         // kept entry k is on the read port
         NS_KLAT: begin
            if (kept_rd_ff.cls == cur_ff.cls) begin
               iw_in    = (ir > il) ? 17'(ir - il) : 17'd0;
               ih_in    = (ib > it) ? 17'(ib - it) : 17'd0;
               state_in = NS_M0;
            end else if (k_ff + 1'b1 == kept_ff) begin
               state_in = NS_DECIDE;
            end else begin
               k_in         = k_ff + 1'b1;
               kept_rd_addr = KeptAw'(k_ff + 1'b1);
            end
         end
         NS_M0: begin
            prod_in  = mul_a * mul_b;
            state_in = NS_M1;
         end
         NS_M1: begin
            inter_in = prod_ff[33:0];
            prod_in  = mul_a * mul_b;
            state_in = NS_M2;
         end
         NS_M2: begin
            area_in  = prod_ff[33:0];
            prod_in  = mul_a * mul_b;
            state_in = NS_M3;
         end
         NS_M3: begin
            uni_in   = area_ff + prod_ff[33:0] - inter_ff;
            state_in = NS_M4;
         end
         // thr * union, then the IoU test
         NS_M4: begin
            prod_in = mul_a * mul_b;
            if (uni_ff != '0 && {1'b0, inter_ff, 16'd0} > (mul_a * mul_b)) begin
               state_in = NS_NEXT;
            end else if (k_ff + 1'b1 == kept_ff) begin
               state_in = NS_DECIDE;
            end else begin
               k_in         = k_ff + 1'b1;
               kept_rd_addr = KeptAw'(k_ff + 1'b1);
               state_in     = NS_KLAT;
            end
         end
         NS_DECIDE: begin
            if (kept_ff == KeptCntW'(MaxKept)) begin
               ovf_in = 1'b1;
            end else begin
               kept_we = 1'b1;
               kept_in = kept_ff + 1'b1;
            end
            state_in = NS_NEXT;
         end
         NS_NEXT: begin
            if (i_ff + 1'b1 == cand_count) begin
               if (kept_ff == '0) begin
                  rsp_in          = '0;
                  rsp_in.overflow = ovf_ff;
                  rsp_in.last     = 1'b1;
                  rsp_valid_in    = 1'b1;
                  state_in        = NS_EMIT;
               end else begin
                  k_in         = '0;
                  kept_rd_addr = '0;
                  state_in     = NS_ELAT;
               end
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = NS_CRD;
            end
         end
         // load result stage from kept entry k
         NS_ELAT: begin
            rsp_in.valid_res  = 1'b1;
            rsp_in.left       = kept_rd_ff.box.l;
            rsp_in.top        = kept_rd_ff.box.t;
            rsp_in.out_width  = kept_rd_ff.box.w;
            rsp_in.out_height = kept_rd_ff.box.h;
            rsp_in.class_id   = kept_rd_ff.cls;
            rsp_in.score_out  = kept_rd_ff.score;
            rsp_in.overflow   = ovf_ff;
            rsp_in.last       = (k_ff + 1'b1 == kept_ff);
            rsp_valid_in      = 1'b1;
            state_in          = NS_EMIT;
         end
         NS_EMIT: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_ff.last) begin
                  done     = 1'b1;
                  state_in = NS_IDLE;
               end else begin
                  k_in         = k_ff + 1'b1;
                  kept_rd_addr = KeptAw'(k_ff + 1'b1);
                  state_in     = NS_ELAT;
               end
            end
         end
         default: state_in = NS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= NS_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      i_ff     <= i_in;
      k_ff     <= k_in;
      kept_ff  <= kept_in;
      ovf_ff   <= ovf_in;
      cur_ff   <= cur_in;
      iw_ff    <= iw_in;
      ih_ff    <= ih_in;
      prod_ff  <= prod_in;
      inter_ff <= inter_in;
      area_ff  <= area_in;
      uni_ff   <= uni_in;
      rsp_ff   <= rsp_in;
   end

   // kept store port
   always_ff @(posedge clock) begin
      if (kept_we) begin
         kept_mem[kept_wr_addr] <= cur_ff;
      end
      kept_rd_ff <= kept_mem[kept_rd_addr];
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
